>>> hw/rtl/gle_pkg.sv
// Shared types, constants and helpers for the GIF LZW encoder.
package gle_pkg;

    localparam int HASH_ENTRIES    = 5003;
    localparam int MAX_CODE_BITS   = 12;
    localparam int SUB_BLOCK_BYTES = 254;
    localparam int ADDR_W          = $clog2(HASH_ENTRIES);
    localparam int DICT_W          = 2 * MAX_CODE_BITS + 8;

    typedef struct packed {
        logic [7:0] pixel;
        logic       first_pixel;
        logic       last_pixel;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       sub_block_end;
        logic [7:0] sub_block_length;
        logic       stream_end;
    } out_item_t;

    typedef struct packed {
        logic [MAX_CODE_BITS-1:0] code;
        logic [MAX_CODE_BITS-1:0] prefix;
        logic [7:0]               suffix;
    } dict_word_t;

    // Code value at which the width grows past w
    function automatic logic [MAX_CODE_BITS:0] limit_for(input logic [3:0] w);
        logic [MAX_CODE_BITS:0] one;
        one = {{MAX_CODE_BITS{1'b0}}, 1'b1};
        if (32'(w) >= MAX_CODE_BITS)
            return one << MAX_CODE_BITS;
        return (one << w) - one;
    endfunction

endpackage

>>> hw/rtl/gif_lzw_encoder_unit.sv
// GIF LZW encoder top level: sequencer, bit packer and hash dictionary.
//
// Input channel in_valid/in_ready/in_data carries one pixel item with first
// and last flags. Output channel out_valid/out_ready/out_data carries one
// packed code-stream byte per item, with sub-block and stream-end marks.
// cfg_valid/cfg_ready/cfg_data writes pixel_bits; it is always ready and
// takes effect at the start of the next image.
// One pixel is handled at a time; in_ready is high only while idle.
// A pixel passes S_HASH, then S_PROBE and S_CHECK per hash probe (one RAM
// port, registered read); each code takes S_EMIT, then S_FLUSH sends bytes.
// Starting an image, or a full table, runs a clearing pass over all 5003
// dictionary RAM entries before the clear code goes out.
// Bytes go out through a one-deep output register; if the receiver stalls,
// the sequencer waits on the next byte and no input is taken.
// Reset clears all control state; pixel_bits returns to 8 and the first
// pixel after reset starts a new image whatever its flags.
module gif_lzw_encoder_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  gle_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output gle_pkg::out_item_t out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [3:0]         cfg_data
);

    localparam int CW = gle_pkg::MAX_CODE_BITS;
    localparam int AW = gle_pkg::ADDR_W;
    localparam int ACC_W = CW + 8;
    localparam logic [AW-1:0] HASH_N = AW'(gle_pkg::HASH_ENTRIES);
    localparam logic [CW:0] CODE_TOP = (CW+1)'(1) << CW;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CLEAR = 3'd1;
    localparam logic [2:0] S_HASH  = 3'd2;
    localparam logic [2:0] S_PROBE = 3'd3;
    localparam logic [2:0] S_CHECK = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;
    localparam logic [2:0] S_FLUSH = 3'd6;

    localparam logic [2:0] R_START = 3'd0;
    localparam logic [2:0] R_MISS  = 3'd1;
    localparam logic [2:0] R_FULL  = 3'd2;
    localparam logic [2:0] R_FIN1  = 3'd3;
    localparam logic [2:0] R_FIN2  = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [2:0]       ret_reg, ret_next;
    logic [3:0]       pb_reg, pb_next;
    logic [3:0]       min_size_reg, min_size_next;
    logic [CW-1:0]    pending_reg, pending_next;
    logic [CW:0]      next_free_reg, next_free_next;
    logic [3:0]       code_width_reg, code_width_next;
    logic [CW:0]      limit_reg, limit_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [4:0]       bit_cnt_reg, bit_cnt_next;
    logic [7:0]       blk_cnt_reg, blk_cnt_next;
    logic [7:0]       px_reg, px_next;
    logic             last_reg, last_next;
    logic             final_reg, final_next;
    logic             clr_full_reg, clr_full_next;
    logic [AW-1:0]    clr_cnt_reg, clr_cnt_next;
    logic [AW-1:0]    probe_reg, probe_next;
    logic [AW-1:0]    disp_reg, disp_next;
    logic [AW-1:0]    slot_reg, slot_next;
    logic [CW-1:0]    emit_reg, emit_next;
    logic             out_valid_reg, out_valid_next;
    gle_pkg::out_item_t out_data_reg, out_data_next;

    logic             ram_we;
    logic [AW-1:0]    ram_addr;
    gle_pkg::dict_word_t ram_wdata, ram_rdata;

    logic [7:0]       px_m;
    logic [8:0]       mask9;
    logic [CW-1:0]    clr_val;
    logic [3:0]       pb_sat, m_new;
    logic [AW-1:0]    hsum, hidx;
    logic             flush_cond, can_load;
    logic [4:0]       bc_after;
    logic [7:0]       cnt1;
    logic             is_last, closing;

    gle_ram #(
        .WIDTH(gle_pkg::DICT_W),
        .DEPTH(gle_pkg::HASH_ENTRIES)
    ) u_dict (
        .clk  (clk),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        mask9      = (9'd1 << (min_size_reg - 4'd1)) - 9'd1;
        px_m       = px_reg & mask9[7:0];
        clr_val    = CW'(1) << (min_size_reg - 4'd1);
        pb_sat     = (pb_reg > 4'd8) ? 4'd8 : pb_reg;
        m_new      = (pb_sat < 4'd2) ? 4'd3 : pb_sat + 4'd1;
        // sum stays below twice the table size
        hsum       = AW'({px_m, 4'b0000}) + AW'(pending_reg);
        hidx       = (hsum >= HASH_N) ? hsum - HASH_N : hsum;
        flush_cond = final_reg ? (bit_cnt_reg != 5'd0) : (bit_cnt_reg >= 5'd8);
        can_load   = !out_valid_reg || out_ready;
        bc_after   = (bit_cnt_reg >= 5'd8) ? bit_cnt_reg - 5'd8 : 5'd0;
        cnt1       = blk_cnt_reg + 8'd1;
        is_last    = final_reg && (bc_after == 5'd0);
        closing    = (32'(cnt1) >= gle_pkg::SUB_BLOCK_BYTES) || is_last;
    end

    always_comb
    begin
        state_next      = state_reg;
        ret_next        = ret_reg;
        pb_next         = pb_reg;
        min_size_next   = min_size_reg;
        pending_next    = pending_reg;
        next_free_next  = next_free_reg;
        code_width_next = code_width_reg;
        limit_next      = limit_reg;
        acc_next        = acc_reg;
        bit_cnt_next    = bit_cnt_reg;
        blk_cnt_next    = blk_cnt_reg;
        px_next         = px_reg;
        last_next       = last_reg;
        final_next      = final_reg;
        clr_full_next   = clr_full_reg;
        clr_cnt_next    = clr_cnt_reg;
        probe_next      = probe_reg;
        disp_next       = disp_reg;
        slot_next       = slot_reg;
        emit_next       = emit_reg;
        out_data_next   = out_data_reg;
        out_valid_next  = out_ready ? 1'b0 : out_valid_reg;
        ram_we          = 1'b0;
        ram_addr        = probe_reg;
        ram_wdata       = '0;

        if (cfg_valid)
            pb_next = cfg_data;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    px_next   = in_data.pixel;
                    last_next = in_data.last_pixel;
                    if (in_data.first_pixel || code_width_reg == 4'd0)
                    begin
                        min_size_next   = m_new;
                        code_width_next = m_new;
                        limit_next      = gle_pkg::limit_for(m_new);
                        next_free_next  = ((CW+1)'(1) << (m_new - 4'd1)) + (CW+1)'(2);
                        acc_next        = '0;
                        bit_cnt_next    = '0;
                        blk_cnt_next    = '0;
                        final_next      = 1'b0;
                        clr_cnt_next    = '0;
                        clr_full_next   = 1'b0;
                        state_next      = S_CLEAR;
                    end
                    else
                    begin
                        state_next = S_HASH;
                    end
                end
            end
            S_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_addr     = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == HASH_N - AW'(1))
                begin
                    emit_next = clr_val;
                    if (clr_full_reg)
                    begin
                        next_free_next = (CW+1)'(clr_val) + (CW+1)'(2);
                        ret_next       = R_FULL;
                    end
                    else
                    begin
                        ret_next = R_START;
                    end
                    state_next = S_EMIT;
                end
            end
            S_HASH:
            begin
                probe_next = hidx;
                disp_next  = (hidx == '0) ? AW'(1) : HASH_N - hidx;
                state_next = S_PROBE;
            end
            S_PROBE:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (ram_rdata.code == '0)
                begin
                    slot_next  = probe_reg;
                    emit_next  = pending_reg;
                    ret_next   = R_MISS;
                    state_next = S_EMIT;
                end
                else if (ram_rdata.prefix == pending_reg && ram_rdata.suffix == px_m)
                begin
                    pending_next = ram_rdata.code;
                    emit_next    = ram_rdata.code;
                    ret_next     = R_FIN1;
                    state_next   = last_reg ? S_EMIT : S_IDLE;
                end
                else
                begin
                    // secondary probe, stepping down with wrap
                    probe_next = (probe_reg >= disp_reg) ? probe_reg - disp_reg
                                                         : probe_reg - disp_reg + HASH_N;
                    state_next = S_PROBE;
                end
            end
            S_EMIT:
            begin
                acc_next     = acc_reg | (ACC_W'(emit_reg) << bit_cnt_reg);
                bit_cnt_next = bit_cnt_reg + 5'(code_width_reg);
                state_next   = S_FLUSH;
            end
            S_FLUSH:
            begin
                if (flush_cond)
                begin
                    if (can_load)
                    begin
                        out_valid_next                 = 1'b1;
                        out_data_next.out_byte         = acc_reg[7:0];
                        out_data_next.sub_block_end    = closing;
                        out_data_next.sub_block_length = closing ? cnt1 : 8'd0;
                        out_data_next.stream_end       = is_last;
                        blk_cnt_next                   = closing ? 8'd0 : cnt1;
                        acc_next                       = acc_reg >> 8;
                        bit_cnt_next                   = bc_after;
                    end
                end
                else
                begin
                    if (next_free_reg > limit_reg && 32'(code_width_reg) < CW)
                    begin
                        code_width_next = code_width_reg + 4'd1;
                        limit_next      = gle_pkg::limit_for(code_width_reg + 4'd1);
                    end
                    case (ret_reg)
                        R_START:
                        begin
                            pending_next = CW'(px_m);
                            emit_next    = CW'(px_m);
                            ret_next     = R_FIN1;
                            state_next   = last_reg ? S_EMIT : S_IDLE;
                        end
                        R_MISS:
                        begin
                            if (next_free_reg < CODE_TOP)
                            begin
                                ram_we           = 1'b1;
                                ram_addr         = slot_reg;
                                ram_wdata.code   = next_free_reg[CW-1:0];
                                ram_wdata.prefix = pending_reg;
                                ram_wdata.suffix = px_m;
                                next_free_next   = next_free_reg + (CW+1)'(1);
                                pending_next     = CW'(px_m);
                                emit_next        = CW'(px_m);
                                ret_next         = R_FIN1;
                                state_next       = last_reg ? S_EMIT : S_IDLE;
                            end
                            else
                            begin
                                clr_cnt_next  = '0;
                                clr_full_next = 1'b1;
                                state_next    = S_CLEAR;
                            end
                        end
                        R_FULL:
                        begin
                            code_width_next = min_size_reg;
                            limit_next      = gle_pkg::limit_for(min_size_reg);
                            pending_next    = CW'(px_m);
                            emit_next       = CW'(px_m);
                            ret_next        = R_FIN1;
                            state_next      = last_reg ? S_EMIT : S_IDLE;
                        end
                        R_FIN1:
                        begin
                            emit_next  = clr_val + CW'(1);
                            final_next = 1'b1;
                            ret_next   = R_FIN2;
                            state_next = S_EMIT;
                        end
                        default:
                        begin
                            code_width_next = '0;
                            acc_next        = '0;
                            bit_cnt_next    = '0;
                            blk_cnt_next    = '0;
                            final_next      = 1'b0;
                            state_next      = S_IDLE;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ret_reg        <= R_START;
            pb_reg         <= 4'd8;
            min_size_reg   <= 4'd3;
            pending_reg    <= '0;
            next_free_reg  <= '0;
            code_width_reg <= '0;
            limit_reg      <= '0;
            acc_reg        <= '0;
            bit_cnt_reg    <= '0;
            blk_cnt_reg    <= '0;
            last_reg       <= 1'b0;
            final_reg      <= 1'b0;
            clr_full_reg   <= 1'b0;
            clr_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ret_reg        <= ret_next;
            pb_reg         <= pb_next;
            min_size_reg   <= min_size_next;
            pending_reg    <= pending_next;
            next_free_reg  <= next_free_next;
            code_width_reg <= code_width_next;
            limit_reg      <= limit_next;
            acc_reg        <= acc_next;
            bit_cnt_reg    <= bit_cnt_next;
            blk_cnt_reg    <= blk_cnt_next;
            last_reg       <= last_next;
            final_reg      <= final_next;
            clr_full_reg   <= clr_full_next;
            clr_cnt_reg    <= clr_cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg       <= px_next;
        probe_reg    <= probe_next;
        disp_reg     <= disp_next;
        slot_reg     <= slot_next;
        emit_reg     <= emit_next;
        out_data_reg <= out_data_next;
    end

`ifndef SYNTH
    // packer never leaves a whole byte behind between items
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (bit_cnt_reg < 5'd8))
        else $error("bit packer holds a full byte while idle");

    assert property (@(posedge clk) disable iff (!rst_n)
        (code_width_reg != 4'd0) |->
            (code_width_reg >= min_size_reg && 32'(code_width_reg) <= CW))
        else $error("code width out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.stream_end) |-> out_data_reg.sub_block_end)
        else $error("stream end without sub-block close");

    // an image is closed once its final byte leaves the flush loop
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FLUSH && ret_reg == R_FIN2 && !flush_cond) |=>
            (code_width_reg == 4'd0 && state_reg == S_IDLE))
        else $error("image not closed after end code");
`endif

endmodule

>>> hw/rtl/gle_ram.sv
// Generic single-port RAM with registered read.
module gle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end

endmodule

>>> verif/gif_lzw_encoder_unit_tb.sv
// Self-checking testbench for the GIF LZW encoder unit.
`timescale 1ns / 100ps

module gif_lzw_encoder_unit_tb;

    localparam int WATCHDOG_CYCLES = 20000;
    localparam int MAX_BYTES_PER_PIXEL = 7;
    localparam int RANDOM_ITEMS = 106;
    localparam int LONG_IMAGE_PIXELS = 40;

    typedef struct {
        int                 cfg;    // -1: no register write before this row
        logic [7:0]         px;
        bit                 first;
        bit                 last;
        int                 nexp;   // >0: expected bytes typed in below
        gle_pkg::out_item_t e0;
        gle_pkg::out_item_t e1;
    } row_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    gle_pkg::in_item_t  in_data;
    logic               out_valid;
    logic               out_ready;
    gle_pkg::out_item_t out_data;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [3:0]         cfg_data;

    gif_lzw_encoder_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Encoder image of the block
    bit [11:0]   tbl_code[gle_pkg::HASH_ENTRIES];
    bit [11:0]   tbl_prefix[gle_pkg::HASH_ENTRIES];
    bit [7:0]    tbl_suffix[gle_pkg::HASH_ENTRIES];
    int unsigned cur_pixel_bits;
    int unsigned prefix_code;
    int unsigned avail_code;
    int unsigned cur_width;
    int unsigned grow_at;
    int unsigned acc_bits;
    int unsigned acc_count;
    int unsigned block_bytes;
    int unsigned root_size;

    gle_pkg::out_item_t step_bytes[$];
    gle_pkg::out_item_t expected_bytes[$];

    int  errors;
    int  pixels_sent;
    int  bytes_seen;
    int  table_clears;
    int  images_done;
    int  cfg_writes;
    int  idle_cycles;
    bit  quiet;
    int  out_stall;

    row_t dir_rows[] = '{
        '{-1, 8'h00, 1'b0, 1'b0, 0, '0, '0},  // no image active yet
        '{-1, 8'hff, 1'b0, 1'b0, 0, '0, '0},
        '{-1, 8'hff, 1'b0, 1'b0, 0, '0, '0},
        '{-1, 8'h00, 1'b0, 1'b0, 0, '0, '0},
        '{-1, 8'hff, 1'b0, 1'b0, 0, '0, '0},
        '{-1, 8'hff, 1'b0, 1'b1, 0, '0, '0},
        // one-pixel image at code size 3: clear 4, pixel 0, end 5
        '{ 1, 8'h00, 1'b1, 1'b1, 2,
           '{8'h44, 1'b0, 8'd0, 1'b0}, '{8'h01, 1'b1, 8'd2, 1'b1}},
        '{-1, 8'hff, 1'b1, 1'b0, 0, '0, '0},  // masked down
        '{-1, 8'hfe, 1'b0, 1'b0, 0, '0, '0},
        '{-1, 8'h01, 1'b0, 1'b1, 0, '0, '0},
        '{ 0, 8'h03, 1'b1, 1'b0, 0, '0, '0},
        '{-1, 8'h03, 1'b0, 1'b0, 0, '0, '0},
        '{-1, 8'h03, 1'b0, 1'b1, 0, '0, '0},
        '{15, 8'hc8, 1'b1, 1'b0, 0, '0, '0},  // saturates to 8
        '{-1, 8'hc8, 1'b0, 1'b0, 0, '0, '0},
        '{-1, 8'hc8, 1'b0, 1'b0, 0, '0, '0},
        '{-1, 8'hc8, 1'b0, 1'b0, 0, '0, '0},
        '{-1, 8'h37, 1'b0, 1'b1, 0, '0, '0},
        '{ 4, 8'h05, 1'b1, 1'b0, 0, '0, '0},
        '{ 2, 8'h09, 1'b0, 1'b0, 0, '0, '0},  // write mid-image
        '{-1, 8'h07, 1'b0, 1'b1, 0, '0, '0},
        '{-1, 8'h03, 1'b1, 1'b0, 0, '0, '0},
        '{-1, 8'h05, 1'b1, 1'b1, 0, '0, '0},  // restart mid-image
        '{ 8, 8'h80, 1'b0, 1'b1, 0, '0, '0}
    };

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic int unsigned width_limit_of(int unsigned w);
        if (w >= gle_pkg::MAX_CODE_BITS)
            return 1 << gle_pkg::MAX_CODE_BITS;
        return (1 << w) - 1;
    endfunction

    function automatic void pack_byte(int unsigned b);
        gle_pkg::out_item_t r;
        if (step_bytes.size() >= MAX_BYTES_PER_PIXEL)
            return;
        r = '0;
        r.out_byte = b[7:0];
        block_bytes++;
        if (block_bytes >= gle_pkg::SUB_BLOCK_BYTES)
        begin
            r.sub_block_end = 1'b1;
            r.sub_block_length = block_bytes[7:0];
            block_bytes = 0;
        end
        step_bytes.push_back(r);
    endfunction

    function automatic void put_code(int unsigned code);
        acc_bits |= (code & 12'hfff) << acc_count;
        acc_count += cur_width;
        while (acc_count >= 8)
        begin
            pack_byte(acc_bits & 8'hff);
            acc_bits >>= 8;
            acc_count -= 8;
        end
        acc_bits &= 24'hffffff;
        if (avail_code > grow_at && cur_width < gle_pkg::MAX_CODE_BITS)
        begin
            cur_width++;
            grow_at = width_limit_of(cur_width);
        end
    endfunction

    function automatic void wipe_table();
        foreach (tbl_code[i])
            tbl_code[i] = '0;
    endfunction

    function automatic void open_image();
        int unsigned pb;
        pb = (cur_pixel_bits > 8) ? 8 : cur_pixel_bits;
        root_size = (pb + 1 < 3) ? 3 : pb + 1;
        cur_width = root_size;
        grow_at = width_limit_of(cur_width);
        avail_code = (1 << (root_size - 1)) + 2;
        acc_bits = 0;
        acc_count = 0;
        block_bytes = 0;
        wipe_table();
        put_code(1 << (root_size - 1));
    endfunction

    function automatic void extend_string(int unsigned px);
        int unsigned clr;
        int          j;
        int          disp;
        clr = 1 << (root_size - 1);
        j = ((px << (gle_pkg::MAX_CODE_BITS - 8)) + prefix_code) % gle_pkg::HASH_ENTRIES;
        if (tbl_code[j] != 0)
        begin
            if (tbl_prefix[j] == prefix_code && tbl_suffix[j] == px)
            begin
                prefix_code = tbl_code[j];
                return;
            end
            disp = (j == 0) ? 1 : gle_pkg::HASH_ENTRIES - j;
            for (int t = 0; t < gle_pkg::HASH_ENTRIES; t++)
            begin
                j -= disp;
                if (j < 0)
                    j += gle_pkg::HASH_ENTRIES;
                if (tbl_code[j] == 0)
                    break;
                if (tbl_prefix[j] == prefix_code && tbl_suffix[j] == px)
                begin
                    prefix_code = tbl_code[j];
                    return;
                end
            end
        end
        put_code(prefix_code);
        if (avail_code < (1 << gle_pkg::MAX_CODE_BITS))
        begin
            tbl_code[j] = avail_code[11:0];
            tbl_prefix[j] = prefix_code[11:0];
            tbl_suffix[j] = px[7:0];
            avail_code++;
        end
        else
        begin
            wipe_table();
            table_clears++;
            avail_code = clr + 2;
            put_code(clr);
            cur_width = root_size;
            grow_at = width_limit_of(cur_width);
        end
        prefix_code = px;
    endfunction

    function automatic void close_image();
        put_code(prefix_code);
        put_code((1 << (root_size - 1)) + 1);
        if (acc_count > 0)
            pack_byte(acc_bits & 8'hff);
        acc_bits = 0;
        acc_count = 0;
        if (step_bytes.size() > 0)
        begin
            if (block_bytes > 0)
            begin
                step_bytes[$].sub_block_end = 1'b1;
                step_bytes[$].sub_block_length = block_bytes[7:0];
            end
            step_bytes[$].stream_end = 1'b1;
        end
        block_bytes = 0;
        cur_width = 0;
        images_done++;
    endfunction

    // Bytes that one accepted pixel completes, left in step_bytes
    function automatic void encode_pixel(gle_pkg::in_item_t it);
        int unsigned px;
        step_bytes.delete();
        if (it.first_pixel || cur_width == 0)
        begin
            open_image();
            prefix_code = it.pixel & ((1 << (root_size - 1)) - 1);
        end
        else
        begin
            px = it.pixel & ((1 << (root_size - 1)) - 1);
            extend_string(px);
        end
        if (it.last_pixel)
            close_image();
    endfunction

    task automatic send_pixel(input logic [7:0] px, input bit first, input bit last,
                              input int nexp, input gle_pkg::out_item_t e0,
                              input gle_pkg::out_item_t e1);
        gle_pkg::in_item_t it;
        it.pixel = px;
        it.first_pixel = first;
        it.last_pixel = last;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        do
            @(posedge clk);
        while (!in_ready);
        encode_pixel(it);
        pixels_sent++;
        if (nexp > 0)
        begin
            if (step_bytes.size() != nexp)
            begin
                $display("%0t: byte count for pixel: expected %0d, actual %0d",
                         $time, nexp, step_bytes.size());
                errors++;
            end
            expected_bytes.push_back(e0);
            if (nexp > 1)
                expected_bytes.push_back(e1);
        end
        else
        begin
            foreach (step_bytes[i])
                expected_bytes.push_back(step_bytes[i]);
        end
        @(negedge clk);
    endtask

    // Called at a falling edge; returns at a falling edge with the block idle
    task automatic settle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_bytes.size() != 0);
        repeat (4) @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_pixel_bits(input logic [3:0] v);
        settle();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cur_pixel_bits = v;
        cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b1;
        cfg_valid = 1'b0;
        cfg_data = '0;
        rst_n = 1'b0;
    end

    // Receiver stalls in random bursts
    initial
    begin
        out_stall = 0;
        forever
        begin
            @(negedge clk);
            if (quiet)
                out_ready <= 1'b1;
            else if (out_stall > 0)
            begin
                out_stall--;
                out_ready <= 1'b0;
            end
            else if ($urandom_range(0, 7) == 0)
            begin
                out_stall = $urandom_range(1, 19) - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        gle_pkg::out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            bytes_seen++;
            if (expected_bytes.size() == 0)
            begin
                $display("%0t: unexpected byte: expected none, actual %h/%b/%0d/%b", $time,
                         out_data.out_byte, out_data.sub_block_end,
                         out_data.sub_block_length, out_data.stream_end);
                errors++;
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (out_data !== want)
                begin
                    $display("%0t: byte mismatch: expected %h/%b/%0d/%b, actual %h/%b/%0d/%b",
                             $time, want.out_byte, want.sub_block_end,
                             want.sub_block_length, want.stream_end,
                             out_data.out_byte, out_data.sub_block_end,
                             out_data.sub_block_length, out_data.stream_end);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles with no handshake at all
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
            || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_CYCLES)
        begin
            $display("%0t: watchdog expired, %0d bytes still expected",
                     $time, expected_bytes.size());
            $display("** gif_lzw_encoder_unit: FAILED **");
            $finish;
        end
    end

    initial
    begin
        int          len;
        int unsigned pb;
        int unsigned mask;
        logic [7:0]  px;
        bit          first;
        bit          last;

        errors = 0;
        pixels_sent = 0;
        bytes_seen = 0;
        table_clears = 0;
        images_done = 0;
        cfg_writes = 0;
        idle_cycles = 0;
        quiet = 1'b0;
        cur_pixel_bits = 8;
        prefix_code = 0;
        avail_code = 0;
        cur_width = 0;
        grow_at = 0;
        acc_bits = 0;
        acc_count = 0;
        block_bytes = 0;
        root_size = 3;
        foreach (tbl_code[i])
        begin
            tbl_code[i] = '0;
            tbl_prefix[i] = '0;
            tbl_suffix[i] = '0;
        end

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].cfg >= 0)
                write_pixel_bits(dir_rows[i].cfg[3:0]);
            send_pixel(dir_rows[i].px, dir_rows[i].first, dir_rows[i].last,
                       dir_rows[i].nexp, dir_rows[i].e0, dir_rows[i].e1);
        end

        // Short random images, random register values between some of them
        while (pixels_sent < dir_rows.size() + RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 2) == 0)
                write_pixel_bits(4'($urandom_range(0, 15)));
            pb = (cur_pixel_bits > 8) ? 8 : ((cur_pixel_bits < 2) ? 2 : cur_pixel_bits);
            mask = (1 << pb) - 1;
            len = $urandom_range(1, 20);
            for (int k = 0; k < len; k++)
            begin
                first = (k == 0) ? ($urandom_range(0, 5) != 0) : ($urandom_range(0, 40) == 0);
                last = (k == len - 1) ? ($urandom_range(0, 7) != 0) : 1'b0;
                if ($urandom_range(0, 7) == 0)
                    px = 8'($urandom_range(0, 255));
                else
                    px = 8'($urandom_range(0, mask));
                send_pixel(px, first, last, 0, '0, '0);
            end
        end

        // Closing image at full width with no idling on either side
        write_pixel_bits(4'd8);
        quiet = 1'b1;
        for (int k = 0; k < LONG_IMAGE_PIXELS; k++)
            send_pixel(8'($urandom_range(0, 255)), k == 0, k == LONG_IMAGE_PIXELS - 1,
                       0, '0, '0);

        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_bytes.size() != 0);
        repeat (50) @(posedge clk);

        $display("Covered %0d pixels in %0d images, %0d bytes, %0d register writes,",
                 pixels_sent, images_done, bytes_seen, cfg_writes);
        $display("and %0d full-table clears.", table_clears);
        if (errors == 0 && expected_bytes.size() == 0)
            $display("** gif_lzw_encoder_unit: PASSED **");
        else
            $display("** gif_lzw_encoder_unit: FAILED **");
        $finish;
    end

endmodule

>>> gif_lzw_encoder_unit.f
hw/rtl/gle_pkg.sv
hw/rtl/gle_ram.sv
hw/rtl/gif_lzw_encoder_unit.sv
verif/gif_lzw_encoder_unit_tb.sv
